/* hw/rtl/fsla_pkg.sv */
package fsla_pkg;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_ALLOC = 2'd0,
        ST_FULL  = 2'd1,
        ST_FREED = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_SLOT_COUNT = 2'd0,
        CFG_OBJ_BYTES  = 2'd1,
        CFG_ALIGN_LOG2 = 2'd2,
        CFG_POOL_BASE  = 2'd3
    } t_cfg_idx;

    localparam int unsigned SIZE_W  = 17;
    localparam int unsigned USED_W  = 11;
    localparam int unsigned CNT_W   = 11;
    localparam int unsigned ADDR_W  = 48;

    localparam logic [10:0] RST_SLOT_COUNT = 11'd1024;
    localparam logic [15:0] RST_OBJ_BYTES  = 16'd8;
    localparam logic [3:0]  RST_ALIGN_LOG2 = 4'd3;
    localparam logic [31:0] RST_POOL_BASE  = 32'd0;
    localparam logic [15:0] MIN_OBJ_BYTES  = 16'd8;
    localparam logic [10:0] USED_MAX       = 11'd2047;

    typedef struct packed {
        t_opcode     opcode;
        logic [9:0]  slot_index;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [9:0]  granted_index;
        logic [47:0] granted_address;
        logic [10:0] used_count;
    } t_rsp;

    typedef struct packed {
        logic        valid;
        t_status     status;
        logic [10:0] used_count;
    } t_stage;

endpackage

/* hw/rtl/fsla_cfg_regs.sv */
module fsla_cfg_regs
    import fsla_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  t_cfg_idx            i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    output logic [CNT_W-1:0]    o_slot_count,
    output logic [SIZE_W-1:0]   o_slot_size,
    output logic [31:0]         o_pool_base
);

    logic [10:0] r_slot_count;
    logic [15:0] r_obj_bytes;
    logic [3:0]  r_align_log2;
    logic [31:0] r_pool_base;

    logic [SIZE_W-1:0] w_obj;
    logic [SIZE_W-1:0] w_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= RST_SLOT_COUNT;
            r_obj_bytes  <= RST_OBJ_BYTES;
            r_align_log2 <= RST_ALIGN_LOG2;
            r_pool_base  <= RST_POOL_BASE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SLOT_COUNT: r_slot_count <= i_cfg_data[10:0];
                CFG_OBJ_BYTES:  r_obj_bytes  <= i_cfg_data[15:0];
                CFG_ALIGN_LOG2: r_align_log2 <= i_cfg_data[3:0];
                CFG_POOL_BASE:  r_pool_base  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Slot size is the object size, at least eight bytes, rounded up to the alignment.
    always_comb begin
        w_obj  = (r_obj_bytes < MIN_OBJ_BYTES) ? SIZE_W'(MIN_OBJ_BYTES)
                                               : SIZE_W'(r_obj_bytes);
        w_mask = (SIZE_W'(1) << r_align_log2) - SIZE_W'(1);
        o_slot_size = (w_obj + w_mask) & ~w_mask;
    end

    assign o_slot_count = r_slot_count;
    assign o_pool_base  = r_pool_base;

endmodule

/* hw/rtl/fsla_link_mem.sv */
module fsla_link_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 11
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/fsla_ctrl.sv */
module fsla_ctrl
    import fsla_pkg::*;
#(
    parameter int unsigned MAX_SLOTS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  t_req                          i_req,
    output logic                          o_busy,
    input  logic [CNT_W-1:0]              i_slot_count,
    input  logic [SIZE_W-1:0]             i_slot_size,
    output logic                          o_mem_we,
    output logic [$clog2(MAX_SLOTS)-1:0]  o_mem_waddr,
    output logic [$clog2(MAX_SLOTS):0]    o_mem_wdata,
    output logic                          o_mem_re,
    output logic [$clog2(MAX_SLOTS)-1:0]  o_mem_raddr,
    input  logic [$clog2(MAX_SLOTS):0]    i_mem_rdata,
    output t_stage                        o_stage,
    output logic [$clog2(MAX_SLOTS)-1:0]  o_slot,
    output logic [SIZE_W-1:0]             o_size
);

    localparam int unsigned SW = $clog2(MAX_SLOTS);
    localparam int unsigned CW = SW + 1;
    localparam int unsigned WW = (CW > CNT_W) ? CW : CNT_W;

    logic              r_busy, n_busy;
    logic              r_pop, n_pop;
    logic [SW-1:0]     r_head, n_head;
    logic              r_head_valid, n_head_valid;
    logic [CW-1:0]     r_fresh, n_fresh;
    logic [USED_W-1:0] r_in_use, n_in_use;
    t_stage            r_stage, n_stage;
    logic [SW-1:0]     r_slot, n_slot;
    logic [SIZE_W-1:0] r_size;

    logic          w_accept;
    logic [WW-1:0] w_eff;
    logic          w_fresh_ok;
    logic          w_idx_ok;
    logic [SW-1:0] w_idx;

    always_comb begin
        w_accept   = i_start && !r_busy;
        w_eff      = (WW'(i_slot_count) > WW'(MAX_SLOTS)) ? WW'(MAX_SLOTS)
                                                          : WW'(i_slot_count);
        w_fresh_ok = WW'(r_fresh) < w_eff;
        w_idx_ok   = WW'(i_req.slot_index) < w_eff;
        w_idx      = SW'(i_req.slot_index);
    end

    always_comb begin
        n_busy       = w_accept;
        n_pop        = 1'b0;
        n_head       = r_head;
        n_head_valid = r_head_valid;
        n_fresh      = r_fresh;
        n_in_use     = r_in_use;
        n_stage      = '{valid: 1'b0, status: ST_FULL, used_count: r_in_use};
        n_slot       = '0;
        o_mem_we     = 1'b0;
        o_mem_waddr  = w_idx;
        o_mem_wdata  = {!r_head_valid, r_head};
        o_mem_re     = 1'b0;
        o_mem_raddr  = r_head;

        if (r_pop) begin
            n_head       = i_mem_rdata[SW-1:0];
            n_head_valid = !i_mem_rdata[SW];
        end

        if (w_accept) begin
            n_stage.valid = 1'b1;
            if (i_req.opcode == OP_ALLOC) begin
                if (r_head_valid) begin
                    n_slot         = r_head;
                    n_pop          = 1'b1;
                    o_mem_re       = 1'b1;
                    n_stage.status = ST_ALLOC;
                end else if (w_fresh_ok) begin
                    n_slot         = r_fresh[SW-1:0];
                    n_fresh        = r_fresh + CW'(1);
                    n_stage.status = ST_ALLOC;
                end else begin
                    n_stage.status = ST_FULL;
                end
                if (n_stage.status == ST_ALLOC && r_in_use != USED_MAX) begin
                    n_in_use = r_in_use + USED_W'(1);
                end
            end else begin
                if (w_idx_ok) begin
                    o_mem_we       = 1'b1;
                    n_head         = w_idx;
                    n_head_valid   = 1'b1;
                    n_stage.status = ST_FREED;
                    if (r_in_use != '0) begin
                        n_in_use = r_in_use - USED_W'(1);
                    end
                end else begin
                    n_stage.status = ST_RANGE;
                end
            end
            n_stage.used_count = n_in_use;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_pop        <= 1'b0;
            r_head_valid <= 1'b0;
            r_fresh      <= '0;
            r_in_use     <= '0;
            r_stage      <= '{valid: 1'b0, status: ST_FULL, used_count: '0};
        end else begin
            r_busy       <= n_busy;
            r_pop        <= n_pop;
            r_head_valid <= n_head_valid;
            r_fresh      <= n_fresh;
            r_in_use     <= n_in_use;
            r_stage      <= n_stage;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_slot <= n_slot;
        if (w_accept) begin
            r_size <= i_slot_size;
        end
    end

    assign o_busy  = r_busy;
    assign o_stage = r_stage;
    assign o_slot  = r_slot;
    assign o_size  = r_size;

endmodule

/* hw/rtl/fsla_addr.sv */
module fsla_addr
    import fsla_pkg::*;
#(
    parameter int unsigned MAX_SLOTS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_stage                        i_stage,
    input  logic [$clog2(MAX_SLOTS)-1:0]  i_slot,
    input  logic [SIZE_W-1:0]             i_size,
    input  logic [31:0]                   i_pool_base,
    output logic                          o_done,
    output t_rsp                          o_rsp
);

    localparam int unsigned SW = $clog2(MAX_SLOTS);
    localparam int unsigned PW = SW + SIZE_W;

    t_stage        r_s1;
    logic [SW-1:0] r_s1_slot;
    logic [PW-1:0] r_prod;
    logic          r_done;
    t_rsp          r_rsp;
    t_rsp          n_rsp;

    always_ff @(posedge i_clk) begin
        r_s1.status     <= i_stage.status;
        r_s1.used_count <= i_stage.used_count;
        r_s1_slot       <= i_slot;
        r_prod          <= PW'(i_slot) * PW'(i_size);
        r_rsp           <= n_rsp;
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_s1.valid <= i_stage.valid;
            r_done     <= r_s1.valid;
        end
    end

    always_comb begin
        n_rsp.status          = r_s1.status;
        n_rsp.used_count      = r_s1.used_count;
        n_rsp.granted_index   = '0;
        n_rsp.granted_address = '0;
        if (r_s1.status == ST_ALLOC) begin
            n_rsp.granted_index   = 10'(r_s1_slot);
            n_rsp.granted_address = ADDR_W'(i_pool_base) + ADDR_W'(r_prod);
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

/* hw/rtl/fixed_slot_free_list_allocator.sv */
// Each request gives one result on o_done for one cycle, registered in r_stage, r_s1 and r_done.
// A new request is not accepted while o_busy is high: o_busy is high for the cycle after
// each accepted request, while the link memory read of an allocate updates the list head.
// A synchronous reset empties the free list, clears the counters and restores the register
// defaults; the link memory is not cleared. The receiver cannot stall results.
module fixed_slot_free_list_allocator
    import fsla_pkg::*;
#(
    parameter int unsigned MAX_SLOTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_req        i_req,
    output logic        o_busy,
    output logic        o_done,
    output t_rsp        o_rsp,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int unsigned SW = $clog2(MAX_SLOTS);

    logic [CNT_W-1:0]  w_slot_count;
    logic [SIZE_W-1:0] w_slot_size;
    logic [31:0]       w_pool_base;
    logic              w_mem_we;
    logic [SW-1:0]     w_mem_waddr;
    logic [SW:0]       w_mem_wdata;
    logic              w_mem_re;
    logic [SW-1:0]     w_mem_raddr;
    logic [SW:0]       w_mem_rdata;
    t_stage            w_stage;
    logic [SW-1:0]     w_slot;
    logic [SIZE_W-1:0] w_size;

    fsla_cfg_regs u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_slot_count (w_slot_count),
        .o_slot_size  (w_slot_size),
        .o_pool_base  (w_pool_base)
    );

    fsla_link_mem #(
        .DEPTH (MAX_SLOTS),
        .WIDTH (SW + 1)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    fsla_ctrl #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_req        (i_req),
        .o_busy       (o_busy),
        .i_slot_count (w_slot_count),
        .i_slot_size  (w_slot_size),
        .o_mem_we     (w_mem_we),
        .o_mem_waddr  (w_mem_waddr),
        .o_mem_wdata  (w_mem_wdata),
        .o_mem_re     (w_mem_re),
        .o_mem_raddr  (w_mem_raddr),
        .i_mem_rdata  (w_mem_rdata),
        .o_stage      (w_stage),
        .o_slot       (w_slot),
        .o_size       (w_size)
    );

    fsla_addr #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_addr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stage     (w_stage),
        .i_slot      (w_slot),
        .i_size      (w_size),
        .i_pool_base (w_pool_base),
        .o_done      (o_done),
        .o_rsp       (o_rsp)
    );

endmodule

/* hw/rtl/fsla_checker.sv */
module fsla_checker
    import fsla_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic o_busy,
    input  logic o_done,
    input  t_rsp o_rsp
);

    logic w_accept;

    assign w_accept = i_start && !o_busy && i_rst_n;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##3 o_done)
        else $error("accepted request produced no result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, 3))
        else $error("result without a matching request");

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_busy ##1 !o_busy))
        else $error("busy window after a request is wrong");

    a_zero_unless_granted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != ST_ALLOC) |->
            (o_rsp.granted_index == '0 && o_rsp.granted_address == '0))
        else $error("grant fields set on a result that is not an allocation");

endmodule

bind fixed_slot_free_list_allocator fsla_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
